>>> src/tsb_pkg.sv
package tsb_pkg;

  localparam int NUM_SLOTS      = 16;
  localparam int FIRE_COUNT_MAX = 255;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(FIRE_COUNT_MAX + 1);
  // elapsed (32b signed) plus a scaled step of up to 32b unsigned, then minus a period
  localparam int ALU_W  = 35;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_DILATION  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA = 1'd1;

  localparam logic [15:0] DILATION_RST  = 16'd256;
  localparam logic [23:0] MAX_DELTA_RST = 24'd100000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_STATUS    = 2'd0,
    KIND_FIRED     = 2'd1,
    KIND_TICK_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NEG_DUR   = 2'd1,
    STAT_OCCUPIED  = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SCALE,
    ST_LOAD,
    ST_FIRE,
    ST_EMIT,
    ST_FIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] dilation;
    logic [23:0] max_delta;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [1:0] status;
    logic [7:0] fire_count;
    logic       last;
  } res_t;

endpackage

>>> src/tsb_in_if.sv
interface tsb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [3:0]        timer_id;
  logic signed [31:0] duration;
  logic [30:0]       start_delay;
  logic              loop_mode;
  logic [23:0]       raw_step;

  modport source (output valid, cmd, timer_id, duration, start_delay, loop_mode, raw_step,
                  input ready);
  modport sink (input valid, cmd, timer_id, duration, start_delay, loop_mode, raw_step,
                output ready);
endinterface

>>> src/tsb_out_if.sv
interface tsb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] slot;
  logic [1:0] status;
  logic [7:0] fire_count;
  logic       last;

  modport source (output valid, kind, slot, status, fire_count, last, input ready);
  modport sink (input valid, kind, slot, status, fire_count, last, output ready);
endinterface

>>> src/tsb_cfg_if.sv
interface tsb_cfg_if;
  import tsb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/tsb_alu.sv
module tsb_alu (
  input  tsb_pkg::alu_op_t                 op,
  input  logic signed [tsb_pkg::ALU_W-1:0] a,
  input  logic signed [tsb_pkg::ALU_W-1:0] b,
  output logic signed [tsb_pkg::ALU_W-1:0] res,
  output logic                             pos,
  output logic                             neg
);
  import tsb_pkg::*;

  logic [ALU_W-1:0] b_op;

  assign b_op = (op == ALU_SUB) ? ~b : b;
  assign res  = a + signed'(b_op) + signed'(ALU_W'(op == ALU_SUB));
  assign neg  = res[ALU_W-1];
  assign pos  = !res[ALU_W-1] && (res != '0);
endmodule

>>> src/tsb_ctrl.sv
module tsb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  tsb_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  logic [3:0]      in_timer_id,
  input  logic [31:0]     in_duration,
  input  logic [30:0]     in_start_delay,
  input  logic            in_loop_mode,
  input  logic [23:0]     in_raw_step,
  output logic            res_valid,
  input  logic            res_ready,
  output tsb_pkg::res_t   res
);
  import tsb_pkg::*;

  // slot store
  logic                     active_r   [NUM_SLOTS];
  logic                     periodic_r [NUM_SLOTS];
  logic [30:0]              period_r   [NUM_SLOTS];
  logic signed [31:0]       elapsed_r  [NUM_SLOTS];

  state_t              state_r, state_nxt;
  logic [23:0]         raw_r, raw_nxt;
  logic [23:0]         step_r, step_nxt;
  logic [31:0]         scaled_r, scaled_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic signed [ALU_W-1:0] e_r, e_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [3:0]          id_r, id_nxt;
  logic [1:0]          status_r, status_nxt;

  alu_op_t                 alu_op;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic                    alu_pos, alu_neg;

  logic [39:0]        prod;
  logic [SLOT_W-1:0]  id_idx;
  logic               id_ok;
  logic               last_slot;
  logic               fire;

  // store write strobes
  logic               create_we;
  logic               remove_we;
  logic               tick_clr;
  logic               el_we;
  logic signed [31:0] el_wd;

  tsb_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .pos (alu_pos),
    .neg (alu_neg)
  );

  assign prod      = step_r * cfg.dilation;
  assign id_idx    = in_timer_id[SLOT_W-1:0];
  assign id_ok     = 32'(in_timer_id) < NUM_SLOTS;
  assign last_slot = idx_r == SLOT_W'(NUM_SLOTS - 1);
  assign fire      = alu_pos && (count_r != CNT_W'(FIRE_COUNT_MAX));
  assign in_ready  = state_r == ST_IDLE;

  // operand select for the shared adder
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      ST_IDLE: begin
        alu_op = ALU_SUB;
        alu_b  = signed'(ALU_W'(in_start_delay));
      end
      ST_CLAMP: begin
        alu_op = ALU_SUB;
        alu_a  = signed'(ALU_W'(cfg.max_delta));
        alu_b  = signed'(ALU_W'(raw_r));
      end
      ST_LOAD: begin
        alu_op = ALU_ADD;
        alu_a  = {{(ALU_W-32){elapsed_r[idx_r][31]}}, elapsed_r[idx_r]};
        alu_b  = signed'(ALU_W'(scaled_r));
      end
      ST_FIRE: begin
        alu_op = ALU_SUB;
        alu_a  = e_r;
        alu_b  = signed'(ALU_W'(period_r[idx_r]));
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    raw_nxt    = raw_r;
    step_nxt   = step_r;
    scaled_nxt = scaled_r;
    idx_nxt    = idx_r;
    e_nxt      = e_r;
    count_nxt  = count_r;
    id_nxt     = id_r;
    status_nxt = status_r;
    create_we  = 1'b0;
    remove_we  = 1'b0;
    tick_clr   = 1'b0;
    el_we      = 1'b0;
    el_wd      = e_r[31:0];
    res_valid  = 1'b0;
    res        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          raw_nxt = in_raw_step;
          id_nxt  = in_timer_id;
          case (in_cmd)
            CMD_TICK: begin
              state_nxt = ST_CLAMP;
            end
            CMD_CREATE: begin
              state_nxt = ST_RESP;
              if (in_duration[31]) begin
                status_nxt = STAT_NEG_DUR;
              end else if (!id_ok || active_r[id_idx]) begin
                status_nxt = STAT_OCCUPIED;
              end else begin
                status_nxt = STAT_OK;
                create_we  = 1'b1;
              end
            end
            CMD_REMOVE: begin
              state_nxt = ST_RESP;
              if (id_ok && active_r[id_idx]) begin
                status_nxt = STAT_OK;
                remove_we  = 1'b1;
              end else begin
                status_nxt = STAT_NOT_FOUND;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CLAMP: begin
        step_nxt  = alu_neg ? cfg.max_delta : raw_r;
        state_nxt = ST_SCALE;
      end

      ST_SCALE: begin
        scaled_nxt = prod[39:8];
        idx_nxt    = '0;
        state_nxt  = ST_LOAD;
      end

      ST_LOAD: begin
        count_nxt = '0;
        e_nxt     = alu_res;
        if (active_r[idx_r]) begin
          state_nxt = ST_FIRE;
        end else if (last_slot) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end

      ST_FIRE: begin
        if (fire) begin
          count_nxt = count_r + 1'b1;
          e_nxt     = alu_res;
          if (!periodic_r[idx_r]) begin
            tick_clr  = 1'b1;
            el_we     = 1'b1;
            el_wd     = alu_res[31:0];
            state_nxt = ST_EMIT;
          end
        end else begin
          // still past the period at saturation: restart from zero
          el_we = 1'b1;
          el_wd = alu_pos ? '0 : e_r[31:0];
          if (count_r != '0) begin
            state_nxt = ST_EMIT;
          end else if (last_slot) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_EMIT: begin
        res_valid      = 1'b1;
        res.kind       = KIND_FIRED;
        res.slot       = 4'(idx_r);
        res.status     = STAT_OK;
        res.fire_count = 8'(count_r);
        res.last       = 1'b0;
        if (res_ready) begin
          if (last_slot) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_FIN: begin
        res_valid = 1'b1;
        res.kind  = KIND_TICK_DONE;
        res.last  = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_RESP: begin
        res_valid  = 1'b1;
        res.kind   = KIND_STATUS;
        res.slot   = id_r;
        res.status = status_r;
        res.last   = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r    <= raw_nxt;
    step_r   <= step_nxt;
    scaled_r <= scaled_nxt;
    idx_r    <= idx_nxt;
    e_r      <= e_nxt;
    count_r  <= count_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        active_r[i]   <= 1'b0;
        periodic_r[i] <= 1'b0;
      end
    end else begin
      if (create_we) begin
        active_r[id_idx]   <= 1'b1;
        periodic_r[id_idx] <= in_loop_mode;
      end
      if (remove_we) begin
        active_r[id_idx]   <= 1'b0;
        periodic_r[id_idx] <= 1'b0;
      end
      if (tick_clr) begin
        active_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (create_we) begin
      period_r[id_idx]  <= in_duration[30:0];
      elapsed_r[id_idx] <= alu_res[31:0];
    end
    if (el_we) begin
      elapsed_r[idx_r] <= el_wd;
    end
  end
endmodule

>>> src/multi_channel_software_timer_bank_top.sv
// Bank of 16 software timers addressed by slot id. Commands: tick (0),
// create (1), remove (2); command code 3 is dropped with no result. Create and
// remove answer one status result. A tick clamps raw_step to max_delta, scales
// it by the Q8.8 dilation factor, adds it to every active slot, and then emits
// one fired result per slot that expired (slot order, fire_count saturating at
// 255) followed by one tick finished result; the final result of every command
// carries last. Times are signed microseconds.
// Throughput: one item at a time; in_ch.ready is high only while the
// sequencer is idle. Create/remove go through accept and a status result.
// A tick goes through accept, clamp and scale, then per slot a load step;
// an active slot then takes compare-and-subtract steps, one per cycle on
// the single shared adder (a periodic slot repeats until it stops firing,
// a one-shot slot retires after its first firing), plus a step to present
// its fired result if it fired, and last the tick finished result. Output
// stalls hold the sequencer in its result states.
// Results leave through a registered output stage, so out_ch.ready may drop
// at any time.
// Configuration: cfg_ch.index 0 = dilation factor (data[15:0], reset 256),
// 1 = max delta (data[23:0], reset 100000). cfg_ch.ready is always high;
// write only while no command is in flight.
module multi_channel_software_timer_bank_top (
  input  logic  clk,
  input  logic  rst_n,
  tsb_in_if.sink    in_ch,
  tsb_out_if.source out_ch,
  tsb_cfg_if.sink   cfg_ch
);
  import tsb_pkg::*;

  cfg_t cfg_r;
  res_t out_data_r;
  logic out_valid_r;

  res_t res;
  logic res_valid;
  logic res_ready;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dilation  <= DILATION_RST;
      cfg_r.max_delta <= MAX_DELTA_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DILATION:  cfg_r.dilation  <= cfg_ch.data[15:0];
        REG_MAX_DELTA: cfg_r.max_delta <= cfg_ch.data[23:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  tsb_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_cmd         (in_ch.cmd),
    .in_timer_id    (in_ch.timer_id),
    .in_duration    (in_ch.duration),
    .in_start_delay (in_ch.start_delay),
    .in_loop_mode   (in_ch.loop_mode),
    .in_raw_step    (in_ch.raw_step),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // output register: takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_data_r.kind;
  assign out_ch.slot       = out_data_r.slot;
  assign out_ch.status     = out_data_r.status;
  assign out_ch.fire_count = out_data_r.fire_count;
  assign out_ch.last       = out_data_r.last;
endmodule

>>> dv/multi_channel_software_timer_bank_top_tb.sv
module multi_channel_software_timer_bank_top_tb;
  import tsb_pkg::*;

  // Command code 3 has no meaning; the bank drops it without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Quiet cycles after the last result before a register write or the end.
  // Covers a dropped command that is still being retired.
  localparam int SETTLE_CYCLES = 16;

  logic clk;
  logic rst_n;

  tsb_in_if  in_ch();
  tsb_out_if out_ch();
  tsb_cfg_if cfg_ch();

  multi_channel_software_timer_bank_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the timer bank: slot state plus the two registers.
  logic        mir_active   [NUM_SLOTS];
  logic        mir_periodic [NUM_SLOTS];
  longint      mir_period   [NUM_SLOTS];
  longint      mir_elapsed  [NUM_SLOTS];
  logic [15:0] mir_dilation;
  logic [23:0] mir_max_delta;

  // Results the bank still owes, oldest first.
  res_t pending_results[$];

  int errors          = 0;
  int in_gap_max      = 0;  // upper bound of the sender's random idle gap before each command
  int out_stall_max   = 0;  // upper bound of the receiver's random stall before each result
  int out_hold_cycles = 0;  // one-shot long hold request for the receiver

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; far beyond the slowest legal run (every tick saturating all
  // sixteen slots with every result stalled the full out_stall_max).
  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void queue_result(kind_t k, logic [3:0] s, status_t st,
                                       logic [7:0] n, logic l);
    res_t r;
    r.kind       = k;
    r.slot       = s;
    r.status     = st;
    r.fire_count = n;
    r.last       = l;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the mirror and queue what it must produce.
  task automatic advance_timer_bank(input logic [1:0] op, input logic [3:0] id,
                                    input logic [31:0] dur, input logic [30:0] delay,
                                    input logic loop_en, input logic [23:0] raw);
    logic [23:0] step;
    longint      scaled;
    longint      e;
    longint      p;
    int          cnt;
    status_t     st;
    case (op)
      CMD_TICK: begin
        step   = (raw > mir_max_delta) ? mir_max_delta : raw;
        scaled = longint'((64'(step) * 64'(mir_dilation)) >> 8);
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!mir_active[s]) continue;
          p   = mir_period[s];
          e   = mir_elapsed[s] + scaled;
          cnt = 0;
          // one firing per period consumed; one-shot slots retire on the first
          while (e > p && cnt < FIRE_COUNT_MAX) begin
            cnt++;
            e -= p;
            if (!mir_periodic[s]) begin
              mir_active[s] = 1'b0;
              break;
            end
          end
          // saturated count: drop the backlog (also ends a zero period)
          if (mir_active[s] && e > p) e = 0;
          mir_elapsed[s] = e;
          if (cnt > 0) queue_result(KIND_FIRED, 4'(s), STAT_OK, 8'(cnt), 1'b0);
        end
        queue_result(KIND_TICK_DONE, 4'd0, STAT_OK, 8'd0, 1'b1);
      end
      CMD_CREATE: begin
        if (dur[31]) begin
          st = STAT_NEG_DUR;
        end else if (mir_active[id]) begin
          st = STAT_OCCUPIED;
        end else begin
          mir_active[id]   = 1'b1;
          mir_periodic[id] = loop_en;
          mir_period[id]   = longint'(dur);
          mir_elapsed[id]  = -longint'(delay);
          st = STAT_OK;
        end
        queue_result(KIND_STATUS, id, st, 8'd0, 1'b1);
      end
      CMD_REMOVE: begin
        st = STAT_NOT_FOUND;
        if (mir_active[id]) begin
          mir_active[id]   = 1'b0;
          mir_periodic[id] = 1'b0;
          st = STAT_OK;
        end
        queue_result(KIND_STATUS, id, st, 8'd0, 1'b1);
      end
      default: ;  // dropped, nothing owed
    endcase
  endtask

  // Offer one command after a random gap and wait for the transfer. valid is
  // left high so a following command with no gap keeps it asserted.
  task automatic send_cmd(input logic [1:0] op, input logic [3:0] id,
                          input logic [31:0] dur, input logic [30:0] delay,
                          input logic loop_en, input logic [23:0] raw);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= op;
    in_ch.timer_id    <= id;
    in_ch.duration    <= dur;
    in_ch.start_delay <= delay;
    in_ch.loop_mode   <= loop_en;
    in_ch.raw_step    <= raw;
    do @(posedge clk); while (!in_ch.ready);
    advance_timer_bank(op, id, dur, delay, loop_en, raw);
  endtask

  // Stop offering, collect everything owed, then let the bank go quiet.
  task automatic settle_bank();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays up so a second write can follow directly.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_DILATION) mir_dilation = val[15:0];
    else mir_max_delta = val[23:0];
  endtask

  // Only called with the bank idle (after settle_bank).
  task automatic apply_config(input logic [CFG_DATA_W-1:0] dil_word,
                              input logic [CFG_DATA_W-1:0] max_word);
    write_reg(REG_DILATION, dil_word);
    write_reg(REG_MAX_DELTA, max_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind=%0d slot=%0d status=%0d count=%0d last=%0d",
                 $time, out_ch.kind, out_ch.slot, out_ch.status, out_ch.fire_count,
                 out_ch.last);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("slot", want.slot, out_ch.slot);
        check_field("status", want.status, out_ch.status);
        check_field("fire_count", want.fire_count, out_ch.fire_count);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: before each result it may drop ready for a random number of
  // cycles. A pending long hold takes the place of one random stall.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready <= 1'b1;
    wait (rst_n);
    forever begin
      if (out_hold_cycles > 0) begin
        stall = out_hold_cycles;
        out_hold_cycles = 0;
      end else begin
        stall = $urandom_range(out_stall_max, 0);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Status codes, check order on create, one-shot retirement, zero period,
  // step clamping, fire count saturation and the dropped command code.
  task automatic test_directed_commands();
    in_gap_max    = 2;
    out_stall_max = 3;
    send_cmd(CMD_REMOVE, 4'd3, 32'd0, 31'd0, 1'b0, 24'd0);              // empty slot
    send_cmd(CMD_CREATE, 4'd0, 32'h8000_0000, 31'd0, 1'b1, 24'd0);      // most negative
    send_cmd(CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 31'd0, 1'b1, 24'd0);      // -1
    send_cmd(CMD_CREATE, 4'd0, 32'd1000, 31'd0, 1'b1, 24'd0);
    send_cmd(CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 31'd0, 1'b1, 24'd0);      // negative wins
    send_cmd(CMD_CREATE, 4'd0, 32'd5, 31'd0, 1'b0, 24'd0);              // occupied
    send_cmd(CMD_CREATE, 4'd15, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 24'd0);
    send_cmd(CMD_CREATE, 4'd5, 32'd0, 31'd0, 1'b1, 24'd0);              // zero period
    send_cmd(CMD_CREATE, 4'd6, 32'd500, 31'd100, 1'b0, 24'd0);          // one-shot
    send_cmd(CMD_CREATE, 4'd7, 32'd0, 31'd0, 1'b0, 24'd0);              // zero, one-shot
    send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'd0);                // no movement
    send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'hFF_FFFF);          // clamped step
    send_cmd(CMD_UNUSED, 4'd9, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 24'hFF_FFFF);
    send_cmd(CMD_REMOVE, 4'd6, 32'd0, 31'd0, 1'b0, 24'd0);              // already retired
    send_cmd(CMD_REMOVE, 4'd0, 32'd0, 31'd0, 1'b0, 24'd0);
    send_cmd(CMD_REMOVE, 4'd0, 32'd0, 31'd0, 1'b0, 24'd0);
    send_cmd(CMD_CREATE, 4'd0, 32'd1, 31'd0, 1'b1, 24'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'd1000);             // saturates slot 0
    send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'd1);
    send_cmd(CMD_REMOVE, 4'd5, 32'd0, 31'd0, 1'b0, 24'd0);
    send_cmd(CMD_REMOVE, 4'd15, 32'd0, 31'd0, 1'b0, 24'd0);
    send_cmd(CMD_REMOVE, 4'd0, 32'd0, 31'd0, 1'b0, 24'd0);
    settle_bank();
  endtask

  task automatic run_config_case(input logic [15:0] dil, input logic [23:0] max_step);
    apply_config(CFG_DATA_W'(dil), max_step);
    send_cmd(CMD_CREATE, 4'd2, 32'd1000, 31'd0, 1'b1, 24'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'hFF_FFFF);
    send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'($urandom));
    send_cmd(CMD_REMOVE, 4'd2, 32'd0, 31'd0, 1'b0, 24'd0);
    settle_bank();
  endtask

  // Register extremes: zero dilation with the widest clamp, largest scaled
  // step, zero clamp, tiny clamp, then back to real time.
  task automatic test_config_extremes();
    in_gap_max    = 0;
    out_stall_max = 0;
    run_config_case(16'd0, 24'hFF_FFFF);
    run_config_case(16'hFFFF, 24'hFF_FFFF);
    run_config_case(16'hFFFF, 24'd0);
    run_config_case(16'd1, 24'd1);
    run_config_case(DILATION_RST, MAX_DELTA_RST);
  endtask

  // Receiver holds off for a long stretch while commands keep coming, so the
  // output stage fills and the bank stops taking input.
  task automatic test_output_backpressure();
    in_gap_max    = 0;
    out_stall_max = 0;
    out_hold_cycles = 400;
    for (int i = 0; i < 4; i++)
      send_cmd(CMD_CREATE, 4'(8 + i), 32'(200 * (i + 1)), 31'd0, 1'b1, 24'd0);
    repeat (8) send_cmd(CMD_TICK, 4'd0, 32'd0, 31'd0, 1'b0, 24'd3000);
    settle_bank();
  endtask

  // Random command mix in four phases, each with its own register setting and
  // idling pattern (none, both sides, sender only, receiver only).
  task automatic test_random_traffic();
    int          pick;
    int          sel;
    logic [3:0]  id;
    logic [31:0] dur;
    logic [30:0] delay;
    logic [23:0] raw;
    logic [7:0]  pad;
    for (int phase = 0; phase < 4; phase++) begin
      in_gap_max    = (phase == 1 || phase == 2) ? 19 : 0;
      out_stall_max = (phase == 1 || phase == 3) ? 19 : 0;
      pad = 8'($urandom);  // unused upper bits of the dilation write
      if (phase == 0) apply_config(CFG_DATA_W'(DILATION_RST), MAX_DELTA_RST);
      else apply_config({pad, 16'($urandom_range(1024, 0))},
                        24'($urandom_range(200000, 0)));
      for (int n = 0; n < 64; n++) begin
        pick  = $urandom_range(99, 0);
        id    = 4'($urandom_range(15, 0));
        dur   = 32'($urandom);
        delay = 31'($urandom);
        raw   = 24'($urandom);
        if (pick < 40) begin
          sel = $urandom_range(9, 0);
          if (sel == 1) dur = 32'(-int'($urandom_range(1000, 1)));
          else if (sel == 2) dur = 32'd0;
          else if (sel > 2) dur = 32'($urandom_range(4000, 1));
          if ($urandom_range(3, 0) != 0) delay = 31'($urandom_range(3000, 0));
          send_cmd(CMD_CREATE, id, dur, delay, 1'($urandom), raw);
        end else if (pick < 70) begin
          if ($urandom_range(7, 0) != 0) raw = 24'($urandom_range(5000, 0));
          send_cmd(CMD_TICK, id, dur, delay, 1'($urandom), raw);
        end else if (pick < 95) begin
          send_cmd(CMD_REMOVE, id, dur, delay, 1'($urandom), raw);
        end else begin
          send_cmd(CMD_UNUSED, id, dur, delay, 1'($urandom), raw);
        end
      end
      settle_bank();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      mir_active[s]   = 1'b0;
      mir_periodic[s] = 1'b0;
      mir_period[s]   = 0;
      mir_elapsed[s]  = 0;
    end
    mir_dilation  = DILATION_RST;
    mir_max_delta = MAX_DELTA_RST;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_TICK;
    in_ch.timer_id    <= 4'd0;
    in_ch.duration    <= 32'd0;
    in_ch.start_delay <= 31'd0;
    in_ch.loop_mode   <= 1'b0;
    in_ch.raw_step    <= 24'd0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_DILATION;
    cfg_ch.data       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_commands();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();
    settle_bank();

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
